FILE: sv/ihex_pkg.sv
// ----------------------------------------------------------------------------
// ihex_pkg
// Shared types and constants for the Intel HEX record parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ihex_pkg;

    // Width of the packed result payload, filled up to whole bytes
    localparam int RESULT_BITS = 74;
    localparam int TDATA_BITS  = ((RESULT_BITS + 7) / 8) * 8;

    // Text and record codes
    localparam logic [7:0] COLON_CHAR    = 8'h3A;
    localparam logic [7:0] REC_TYPE_DATA = 8'h00;
    localparam logic [7:0] REC_TYPE_END  = 8'h01;

    // Input action codes
    localparam logic ACTION_CHAR = 1'b0;
    localparam logic ACTION_END  = 1'b1;

    // Result kind codes
    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    // Parser phase
    typedef enum logic [2:0] {
        PH_WAIT,
        PH_LEN,
        PH_ADDR_HI,
        PH_ADDR_LO,
        PH_TYPE,
        PH_DATA
    } phase_t;

    // One result item
    typedef struct packed {
        logic        kind;
        logic [15:0] write_address;
        logic [7:0]  write_data;
        logic [15:0] extent_start;
        logic [16:0] extent_end;
        logic [16:0] written_size;
    } result_t;

endpackage : ihex_pkg

`default_nettype wire

FILE: sv/ihex_core.sv
// ----------------------------------------------------------------------------
// ihex_core
// Record state machine: decodes one request per cycle and forms at most one
// result (a memory byte write or the extent report) for the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ihex_core
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             action,
    input  wire logic [7:0]       character,
    output      logic             res_valid,
    output      ihex_pkg::result_t res
);
    import ihex_pkg::*;

    // Map a text byte to its hex digit value, anything else to zero
    function automatic logic [3:0] hex_digit(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'd0;
            if (c >= 8'h30 && c <= 8'h39)
            begin
                d = c - 8'h30;
            end
            else if (c >= 8'h41 && c <= 8'h46)
            begin
                d = c - 8'h41 + 8'd10;
            end
            else if (c >= 8'h61 && c <= 8'h66)
            begin
                d = c - 8'h61 + 8'd10;
            end
            hex_digit = d[3:0];
        end
    endfunction

    phase_t      phase_reg,          phase_next;
    logic        second_nibble_reg,  second_nibble_next;
    logic [3:0]  high_nibble_reg,    high_nibble_next;
    logic [7:0]  bytes_left_reg,     bytes_left_next;
    logic [15:0] record_address_reg, record_address_next;
    logic [15:0] lowest_start_reg,   lowest_start_next;
    logic [16:0] highest_end_reg,    highest_end_next;

    logic [7:0]  byte_val;
    logic [16:0] end_val;
    logic [16:0] size_val;

    // Hold parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_WAIT;
            second_nibble_reg  <= 1'b0;
            high_nibble_reg    <= 4'd0;
            bytes_left_reg     <= 8'd0;
            record_address_reg <= 16'd0;
            lowest_start_reg   <= 16'hFFFF;
            highest_end_reg    <= 17'd0;
        end
        else
        begin
            phase_reg          <= phase_next;
            second_nibble_reg  <= second_nibble_next;
            high_nibble_reg    <= high_nibble_next;
            bytes_left_reg     <= bytes_left_next;
            record_address_reg <= record_address_next;
            lowest_start_reg   <= lowest_start_next;
            highest_end_reg    <= highest_end_next;
        end
    end

    // Assemble the byte, the record end and the report size
    assign byte_val = {high_nibble_reg, hex_digit(character)};
    assign end_val  = {1'b0, record_address_reg} + {9'd0, bytes_left_reg};
    assign size_val = (highest_end_reg > {1'b0, lowest_start_reg})
                    ? (highest_end_reg - {1'b0, lowest_start_reg}) : 17'd0;

    // Advance the parser and form the result
    always_comb
    begin
        phase_next          = phase_reg;
        second_nibble_next  = second_nibble_reg;
        high_nibble_next    = high_nibble_reg;
        bytes_left_next     = bytes_left_reg;
        record_address_next = record_address_reg;
        lowest_start_next   = lowest_start_reg;
        highest_end_next    = highest_end_reg;
        res_valid           = 1'b0;
        res                 = '0;

        if (in_valid)
        begin
            if (action == ACTION_END)
            begin
                // Report the extent, leave the parse untouched
                res_valid        = 1'b1;
                res.kind         = KIND_REPORT;
                res.extent_start = lowest_start_reg;
                res.extent_end   = highest_end_reg;
                res.written_size = size_val;
            end
            else if (phase_reg == PH_WAIT)
            begin
                // Skip text until a colon opens a record
                if (character == COLON_CHAR)
                begin
                    phase_next         = PH_LEN;
                    second_nibble_next = 1'b0;
                    high_nibble_next   = 4'd0;
                end
            end
            else if (!second_nibble_reg)
            begin
                high_nibble_next   = hex_digit(character);
                second_nibble_next = 1'b1;
            end
            else
            begin
                second_nibble_next = 1'b0;
                case (phase_reg)
                    PH_LEN:
                    begin
                        bytes_left_next = byte_val;
                        phase_next      = PH_ADDR_HI;
                    end
                    PH_ADDR_HI:
                    begin
                        record_address_next = {byte_val, 8'd0};
                        phase_next          = PH_ADDR_LO;
                    end
                    PH_ADDR_LO:
                    begin
                        record_address_next = {record_address_reg[15:8], byte_val};
                        phase_next          = PH_TYPE;
                    end
                    PH_TYPE:
                    begin
                        // Every record but end widens the extent
                        if (byte_val != REC_TYPE_END)
                        begin
                            if (record_address_reg < lowest_start_reg)
                            begin
                                lowest_start_next = record_address_reg;
                            end
                            if (end_val > highest_end_reg)
                            begin
                                highest_end_next = end_val;
                            end
                        end
                        if (byte_val == REC_TYPE_DATA && bytes_left_reg != 8'd0)
                        begin
                            phase_next = PH_DATA;
                        end
                        else
                        begin
                            phase_next = PH_WAIT;
                        end
                    end
                    PH_DATA:
                    begin
                        // Emit one byte write, the address wraps at 64K
                        res_valid           = 1'b1;
                        res.kind            = KIND_WRITE;
                        res.write_address   = record_address_reg;
                        res.write_data      = byte_val;
                        record_address_next = record_address_reg + 16'd1;
                        bytes_left_next     = bytes_left_reg - 8'd1;
                        if (bytes_left_reg == 8'd1)
                        begin
                            phase_next = PH_WAIT;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_WAIT;
                    end
                endcase
            end
        end
    end

    // A data phase always has bytes left to take
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (bytes_left_reg != 8'd0))
    else $error("data phase with no bytes left");

    // No held digit while waiting for a colon
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_WAIT) |-> !second_nibble_reg)
    else $error("half byte held outside a record");

    // Once some end is recorded, the start lies at or below it
    assert property (@(posedge clk) disable iff (!rst_n)
        (highest_end_reg != 17'd0) |-> ({1'b0, lowest_start_reg} <= highest_end_reg))
    else $error("extent start above extent end");

endmodule : ihex_core

`default_nettype wire

FILE: sv/ihex_out_buf.sv
// ----------------------------------------------------------------------------
// ihex_out_buf
// Output register with a skid stage, so a request is taken while a finished
// result still waits on the result side.
// ----------------------------------------------------------------------------
`default_nettype none

module ihex_out_buf
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire ihex_pkg::result_t in_data,
    output      logic              ready,
    output      logic              out_valid,
    output      ihex_pkg::result_t out_data,
    input  wire logic              out_ready
);
    import ihex_pkg::*;

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;

    assign ready     = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Hold the valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Hold the payloads
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    // Refill the output slot from the skid stage first, else from the core
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (out_ready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = in_valid;
                out_data_next  = in_data;
            end
        end
        else if (in_valid)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    // A new result never arrives while the skid stage is full
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> !skid_valid_reg)
    else $error("result arrived with skid stage full");

    // The skid stage fills only behind a waiting output
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
    else $error("skid stage full with output empty");

    // The skid stage fills only when the output was stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !out_ready))
    else $error("skid stage filled without a stall");

endmodule : ihex_out_buf

`default_nettype wire

FILE: sv/intel_hex_record_parser.sv
// ----------------------------------------------------------------------------
// intel_hex_record_parser
// Parses Intel HEX text into memory byte writes and a final extent report.
//
//   Channel   Dir  Handshake                    Content
//   s_axis    in   s_axis_tvalid/s_axis_tready  one text character or end
//   m_axis    out  m_axis_tvalid/m_axis_tready  byte write or extent report
//
// One request is taken every cycle while s_axis_tready is high; each request
// is decoded by the record state machine in that cycle and its result is
// registered in the output register. Reset (rst_n low) returns to waiting for a
// colon with an empty extent. A stalled result side fills the skid stage behind
// the output register; s_axis_tready drops only while that stage is full.
// ----------------------------------------------------------------------------
`default_nettype none

module intel_hex_record_parser
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] character
    input  wire logic        s_axis_tuser,   // [0] action
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [79:0] m_axis_tdata,   // [15:0] write_address,
                                             // [23:16] write_data,
                                             // [39:24] extent_start,
                                             // [56:40] extent_end,
                                             // [73:57] written_size, rest 0
    output      logic        m_axis_tuser    // [0] kind
);
    import ihex_pkg::*;

    logic    take;
    logic    res_valid;
    result_t res;
    result_t out_res;

    // Accept a request when both sides agree
    assign take = s_axis_tvalid && s_axis_tready;

    ihex_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (take),
        .action    (s_axis_tuser),
        .character (s_axis_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    ihex_out_buf u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res_valid),
        .in_data   (res),
        .ready     (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (out_res),
        .out_ready (m_axis_tready)
    );

    // Pack the result fields, lowest field first
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tdata = {
        6'd0,
        out_res.written_size,
        out_res.extent_end,
        out_res.extent_start,
        out_res.write_data,
        out_res.write_address
    };

endmodule : intel_hex_record_parser

`default_nettype wire

FILE: tb/intel_hex_record_parser_checker.sv
// ----------------------------------------------------------------------------
// intel_hex_record_parser_checker
// Watches both stream channels of the parser and tracks the record state of
// every accepted text character or end request. From that state it predicts
// the memory writes and extent reports, then compares each result field by
// field in arrival order. The top reads the mismatch count and the number of
// results still outstanding.
// ----------------------------------------------------------------------------
module intel_hex_record_parser_checker
    import ihex_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,
    input  logic                  s_axis_tuser,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [TDATA_BITS-1:0] m_axis_tdata,
    input  logic                  m_axis_tuser,
    output int                    mismatches,
    output int                    pending_results
);

    localparam int MAX_SHOWN = 10;

    // Parser state as seen from the text stream
    phase_t      ph;
    logic        low_digit_next;
    logic [3:0]  held_digit;
    logic [7:0]  data_left;
    logic [15:0] next_addr;
    logic [15:0] low_start;
    logic [16:0] high_end;

    // Writes and reports the parser still owes, oldest first
    result_t parser_out_q[$];

    function automatic logic [3:0] digit_value(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return 4'(c - "0");
        if (c >= "A" && c <= "F")
            return 4'(c - "A" + 10);
        if (c >= "a" && c <= "f")
            return 4'(c - "a" + 10);
        return 4'h0;
    endfunction

    // Advance the record state by one request and queue what it emits
    task automatic parse_step(input logic act, input logic [7:0] c);
        result_t     r;
        logic [7:0]  b;
        logic [16:0] span;
        r = '0;
        if (act == ACTION_END)
        begin
            r.kind         = KIND_REPORT;
            r.extent_start = low_start;
            r.extent_end   = high_end;
            r.written_size = (high_end > {1'b0, low_start}) ?
                             high_end - {1'b0, low_start} : 17'd0;
            parser_out_q.push_back(r);
            return;
        end
        if (ph == PH_WAIT)
        begin
            if (c == COLON_CHAR)
            begin
                ph             = PH_LEN;
                low_digit_next = 1'b0;
                held_digit     = 4'h0;
            end
            return;
        end
        // Hold the high digit until its partner arrives
        if (!low_digit_next)
        begin
            held_digit     = digit_value(c);
            low_digit_next = 1'b1;
            return;
        end
        low_digit_next = 1'b0;
        b = {held_digit, digit_value(c)};
        case (ph)
            PH_LEN:
            begin
                data_left = b;
                ph        = PH_ADDR_HI;
            end
            PH_ADDR_HI:
            begin
                next_addr = {b, 8'h00};
                ph        = PH_ADDR_LO;
            end
            PH_ADDR_LO:
            begin
                next_addr[7:0] = b;
                ph             = PH_TYPE;
            end
            PH_TYPE:
            begin
                // Every record but the end record widens the extent
                if (b != REC_TYPE_END)
                begin
                    if (next_addr < low_start)
                        low_start = next_addr;
                    span = {1'b0, next_addr} + {9'd0, data_left};
                    if (span > high_end)
                        high_end = span;
                end
                ph = (b == REC_TYPE_DATA && data_left != 8'd0) ? PH_DATA : PH_WAIT;
            end
            default:
            begin
                r.kind          = KIND_WRITE;
                r.write_address = next_addr;
                r.write_data    = b;
                parser_out_q.push_back(r);
                next_addr = next_addr + 16'd1;
                data_left = data_left - 8'd1;
                if (data_left == 8'd0)
                    ph = PH_WAIT;
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [16:0] want,
                               input logic [16:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
                $display("mismatch in %s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : watch
        result_t want;
        if (!rst_n)
        begin
            ph              = PH_WAIT;
            low_digit_next  = 1'b0;
            held_digit      = 4'h0;
            data_left       = 8'd0;
            next_addr       = 16'd0;
            low_start       = 16'hFFFF;
            high_end        = 17'd0;
            mismatches      = 0;
            pending_results = 0;
            parser_out_q.delete();
        end
        else
        begin
            // Compare the result leaving the block at this edge
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (parser_out_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("unexpected result: kind %0b data 0x%0h",
                                 m_axis_tuser, m_axis_tdata);
                end
                else
                begin
                    want = parser_out_q.pop_front();
                    check_field("kind", {16'd0, want.kind}, {16'd0, m_axis_tuser});
                    check_field("write_address", {1'b0, want.write_address},
                                {1'b0, m_axis_tdata[15:0]});
                    check_field("write_data", {9'd0, want.write_data},
                                {9'd0, m_axis_tdata[23:16]});
                    check_field("extent_start", {1'b0, want.extent_start},
                                {1'b0, m_axis_tdata[39:24]});
                    check_field("extent_end", want.extent_end, m_axis_tdata[56:40]);
                    check_field("written_size", want.written_size, m_axis_tdata[73:57]);
                    check_field("padding", 17'd0,
                                {{(17 - (TDATA_BITS - RESULT_BITS)){1'b0}},
                                 m_axis_tdata[TDATA_BITS-1:RESULT_BITS]});
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                parse_step(s_axis_tuser, s_axis_tdata);
            pending_results = parser_out_q.size();
        end
    end

endmodule : intel_hex_record_parser_checker

FILE: tb/intel_hex_record_parser_tb.sv
// ----------------------------------------------------------------------------
// intel_hex_record_parser_tb
// Feeds the parser with directed Intel HEX text, then with random records,
// broken records and noise under three idling mixes on both channels. The
// checker beside the block predicts and compares every result; this module
// drives stimulus, runs a stall watchdog and gives the verdict.
// ----------------------------------------------------------------------------
module intel_hex_record_parser_tb;

    import ihex_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int PHASE_ITEMS  = 470;
    localparam int TAIL_CYCLES  = 20;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = 8'h00;
    logic                  s_axis_tuser  = ACTION_CHAR;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [TDATA_BITS-1:0] m_axis_tdata;
    logic                  m_axis_tuser;

    int mismatches;
    int pending;
    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int text_items   = 0;
    int quiet_cycles = 0;

    intel_hex_record_parser i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    intel_hex_record_parser_checker i_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .mismatches      (mismatches),
        .pending_results (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stall the result side at random
    always @(negedge clk)
        m_axis_tready <= rst_n && ($urandom_range(99) >= snk_idle_pct);

    // End the run if nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("intel_hex_record_parser_tb NOT OK");
                $finish;
            end
        end
    end

    // Offer one request, with random idle cycles ahead of it
    task automatic send_item(input logic act, input logic [7:0] c);
        while ($urandom_range(99) < src_idle_pct)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tuser  <= act;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(ACTION_CHAR, s[i]);
    endtask

    task automatic send_end();
        send_item(ACTION_END, 8'($urandom_range(255)));
        text_items++;
    endtask

    // Hold the sender off until every owed result has come out
    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return 8'("0" + n);
        return ($urandom_range(1) != 0) ? 8'("A" + n - 10) : 8'("a" + n - 10);
    endfunction

    // Send a record, optionally with one character spoiled
    task automatic send_record(input int len, input logic [15:0] addr,
                               input logic [7:0] rkind, input bit spoil);
        byte unsigned txt[$];
        logic [7:0]   b;
        int           pos;
        txt.push_back(COLON_CHAR);
        for (int i = 0; i < len + 5; i++)
        begin
            case (i)
                0:       b = 8'(len);
                1:       b = addr[15:8];
                2:       b = addr[7:0];
                3:       b = rkind;
                default: b = 8'($urandom_range(255));
            endcase
            txt.push_back(hex_char(b[7:4]));
            txt.push_back(hex_char(b[3:0]));
        end
        if ($urandom_range(1) != 0)
        begin
            txt.push_back(8'h0D);
            txt.push_back(8'h0A);
        end
        if (spoil)
        begin
            pos = $urandom_range(txt.size() - 1, 1);
            txt[pos] = ($urandom_range(1) != 0) ? COLON_CHAR : 8'("g" + $urandom_range(19));
        end
        foreach (txt[i])
            send_item(ACTION_CHAR, txt[i]);
        text_items += txt.size();
    endtask

    // One random chunk: mostly well-formed records, then ends, noise and cut records
    task automatic random_chunk();
        int          pick;
        int          len;
        int          n;
        logic [15:0] addr;
        logic [7:0]  rkind;
        pick = $urandom_range(99);
        if (pick < 75)
        begin
            n = $urandom_range(99);
            if (n < 2)
                len = 255;
            else if (n < 55)
                len = $urandom_range(4);
            else
                len = $urandom_range(16);
            n = $urandom_range(9);
            if (n == 0)
                addr = 16'hFFFF - 16'($urandom_range(8));
            else if (n == 1)
                addr = 16'($urandom_range(8));
            else
                addr = 16'($urandom_range(16'hFFFF));
            n = $urandom_range(9);
            rkind = (n < 7) ? REC_TYPE_DATA :
                    (n < 8) ? REC_TYPE_END : 8'($urandom_range(255, 2));
            send_record(len, addr, rkind, pick >= 68);
        end
        else if (pick < 85)
            send_end();
        else if (pick < 93)
        begin
            n = $urandom_range(6, 1);
            repeat (n)
                send_item(ACTION_CHAR, 8'($urandom_range(255)));
            text_items += n;
        end
        else
        begin
            // Cut a record short with an end request
            send_item(ACTION_CHAR, COLON_CHAR);
            n = $urandom_range(9);
            repeat (n)
                send_item(ACTION_CHAR, hex_char(4'($urandom_range(15))));
            text_items += n + 1;
            send_end();
        end
    endtask

    initial
    begin : stimulus
        int target;
        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        src_idle_pct = 22;
        snk_idle_pct = 82;

        // Empty extent, zero-length data at the top, address wrap with mixed case
        send_end();
        send_text(":00FFFF00");
        send_end();
        send_text(":02FFFF00aBcD");
        send_end();
        // Colon and letters inside a record, a type above end, an end mid-record
        send_text(":0:ZZ0105");
        send_text(":01");
        send_end();

        for (int p = 0; p < 3; p++)
        begin
            case (p)
                0:
                begin
                    src_idle_pct = 22;
                    snk_idle_pct = 82;
                end
                1:
                begin
                    src_idle_pct = 82;
                    snk_idle_pct = 22;
                end
                default:
                begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            target = text_items + PHASE_ITEMS;
            while (text_items < target)
                random_chunk();
            send_end();
            drain_results();
        end

        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("intel_hex_record_parser_tb OK");
        else
            $display("intel_hex_record_parser_tb NOT OK");
        $finish;
    end

endmodule : intel_hex_record_parser_tb
